// ===== hw/rtl/pof_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pattern occurrence finder: sizes, register indexes and
// the packed word types of the input and result channels. No dependencies.
package pof_pkg;

    // Window depth in bytes and width of the stream position counter
    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;

    // Pattern storage as written through the configuration port
    localparam int PAT_WORDS   = 4;
    localparam int PAT_BYTES   = 8 * PAT_WORDS;
    localparam int WORD_BITS   = 64;
    localparam int LEN_REG_W   = 6;

    // Derived widths
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int WIN_BITS    = 8 * MAX_PATTERN;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_stream;
    } in_word_t;

    typedef struct packed {
        logic [31:0] match_offset;
        logic        offset_wrapped;
    } out_word_t;

endpackage

// ===== hw/rtl/pattern_occurrence_finder.sv =====
`timescale 1ns / 1ps
// Pattern occurrence finder: non-overlapping search of a byte stream for a
// configured pattern of up to 32 bytes. Depends on pof_pkg.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall  | data_byte, last_in_stream
//  out     | output    | out_valid/out_stall| match_offset, offset_wrapped
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte is taken every cycle while the input is not stalled. A byte is registered
// in the input stage on acceptance and compared there against the whole window; a hit
// loads the output register when the byte moves on from the input stage.
// The output register holds a result until it is taken; a stall on the
// output stalls the input only when the staged byte cannot move on.
// Reset clears the stream state and sets the pattern to zero, length one.
// cfg_ready is always high: a register write is taken as soon as it is offered.
module pattern_occurrence_finder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pof_pkg::in_word_t                   in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pof_pkg::out_word_t                  out_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pof_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pof_pkg::WORD_BITS-1:0]       cfg_data
);
    import pof_pkg::*;

    // Configuration registers
    logic [WORD_BITS-1:0]  pattern_word_reg [PAT_WORDS];
    logic [LEN_REG_W-1:0]  pattern_length_reg;

    // Input stage
    logic                  s1_valid_reg;
    in_word_t              s1_word_reg;

    // Stream state
    logic [7:0]            win_reg  [MAX_PATTERN];
    logic [7:0]            win_next [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]      seen_reg, seen_next;
    logic [LEN_W-1:0]      overlap_reg, overlap_next;
    logic                  wrap_reg, wrap_next;

    // Output register
    logic                  out_valid_reg;
    out_word_t             out_word_reg, out_word_next;

    // Datapath signals
    logic [7:0]            pat_byte [MAX_PATTERN];
    logic [WIN_BITS-1:0]   pat_rev;
    logic [WIN_BITS-1:0]   pat_aligned;
    logic [LEN_W-1:0]      len_eff;
    logic [LEN_W-1:0]      len_m1;
    logic [LEN_W-1:0]      shift_bytes;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                  hit;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    logic [OFFSET_BITS-1:0] start_pos;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Clamp the length to the window depth
    always_comb
    begin
        if (32'(pattern_length_reg) > 32'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = LEN_W'(pattern_length_reg);
        end
        len_m1      = len_eff - LEN_W'(1);
        shift_bytes = LEN_W'(MAX_PATTERN) - len_eff;
    end

    // Unpack pattern bytes; bytes past the register set read as zero
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (i < PAT_BYTES)
            begin
                pat_byte[i] = pattern_word_reg[2'(i >> 3)][8*(i & 7) +: 8];
            end
            else
            begin
                pat_byte[i] = 8'h00;
            end
        end
    end

    // Reverse the pattern and shift it so pattern byte len-1-k meets window byte k
    always_comb
    begin
        for (int m = 0; m < MAX_PATTERN; m++)
        begin
            pat_rev[8*m +: 8] = pat_byte[MAX_PATTERN-1-m];
        end
        pat_aligned = pat_rev >> {shift_bytes, 3'b000};
    end

    // Shift the new byte into the window, newest at index 0
    always_comb
    begin
        win_next[0] = s1_word_reg.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    // Compare every window byte in parallel; bytes beyond the length always pass
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            byte_ok[k] = (k >= int'(len_eff)) || (win_next[k] == pat_aligned[8*k +: 8]);
        end
    end

    assign seen_next = (seen_reg == LEN_W'(MAX_PATTERN)) ? seen_reg : seen_reg + LEN_W'(1);
    assign hit       = (overlap_reg == '0) && (len_eff != '0) && (seen_next >= len_eff)
                       && (&byte_ok);
    assign start_pos = pos_reg - OFFSET_BITS'(len_m1);

    // Next stream state: count down a covered stretch, wrap the position
    always_comb
    begin
        pos_next  = pos_reg + OFFSET_BITS'(1);
        wrap_next = wrap_reg || (pos_next == '0);
        if (overlap_reg != '0)
        begin
            overlap_next = overlap_reg - LEN_W'(1);
        end
        else if (hit)
        begin
            overlap_next = len_m1;
        end
        else
        begin
            overlap_next = overlap_reg;
        end
        out_word_next.match_offset   = 32'(start_pos);
        out_word_next.offset_wrapped = wrap_reg;
    end

    // Control state, configuration and stream counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PAT_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
            pattern_length_reg <= LEN_REG_W'(1);
            s1_valid_reg       <= 1'b0;
            pos_reg            <= '0;
            seen_reg           <= '0;
            overlap_reg        <= '0;
            wrap_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            // Take a register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_data;
                    REG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_data;
                    REG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_data;
                    REG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_data;
                    REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_REG_W-1:0];
                    default: ;
                endcase
            end

            // Hold or refill the input stage
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Advance the stream state; the final byte clears it
            if (advance)
            begin
                if (s1_word_reg.last_in_stream)
                begin
                    pos_reg     <= '0;
                    seen_reg    <= '0;
                    overlap_reg <= '0;
                    wrap_reg    <= 1'b0;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    seen_reg    <= seen_next;
                    overlap_reg <= overlap_next;
                    wrap_reg    <= wrap_next;
                end
            end

            // Load or drop the result word
            if (out_free)
            begin
                out_valid_reg <= advance && hit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg <= in_word;
        end
        if (advance)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
        if (out_free && advance && hit)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

// ===== hw/rtl/pof_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the pattern occurrence finder, bound to the top level.
// Depends on pof_pkg and pattern_occurrence_finder.
module pof_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  pof_pkg::in_word_t             in_word,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  pof_pkg::out_word_t            out_word
);
    import pof_pkg::*;

    // A stalled result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

    // A stalled input word is held by the sender
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

    // Back-pressure on the input only comes from a stalled full output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while output could move");

    // A fresh result follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a byte two cycles before");

endmodule

bind pattern_occurrence_finder pof_checker u_pof_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
